>>> hdl/sprs_pkg.sv
// Shared types, character codes and helper functions for the shell pipe and
// redirection syntax checker. No dependencies.

package sprs_pkg;

	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} quote_t;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_OP_LT      = 3'd1,
		PH_OP_GT      = 3'd2,
		PH_AFTER_OP   = 3'd3,
		PH_WORD       = 3'd4,
		PH_WORD_QUOTE = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		PE_NONE        = 2'd0,
		PE_REPEATED    = 2'd1,
		PE_END_OR_PIPE = 2'd2
	} perr_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_LEADING_PIPE = 3'd1,
		ST_REDIR_NOFILE = 3'd2,
		ST_REPEAT_PIPE  = 3'd3,
		ST_PIPE_AT_END  = 3'd4
	} status_t;

	typedef struct packed {
		phase_t     redir_phase;
		quote_t     redir_outer_quote;
		quote_t     file_word_quote;
		quote_t     pipe_pass_quote;
		logic       previous_was_pipe;
		logic       pipe_lookahead_pending;
		logic       seen_nonblank;
		logic       leading_pipe_flag;
		logic       redir_error_flag;
		perr_t      pipe_error_code;
	} chk_state_t;

	localparam chk_state_t CHK_RESET = '{
		redir_phase:            PH_IDLE,
		redir_outer_quote:      Q_NONE,
		file_word_quote:        Q_NONE,
		pipe_pass_quote:        Q_NONE,
		previous_was_pipe:      1'b0,
		pipe_lookahead_pending: 1'b0,
		seen_nonblank:          1'b0,
		leading_pipe_flag:      1'b0,
		redir_error_flag:       1'b0,
		pipe_error_code:        PE_NONE
	};

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_redir(input logic [7:0] c);
		return (c == CH_LT) || (c == CH_GT);
	endfunction

	function automatic quote_t quote_code(input logic [7:0] c);
		if (c == CH_SQUOTE) return Q_SINGLE;
		if (c == CH_DQUOTE) return Q_DOUBLE;
		return Q_NONE;
	endfunction

	function automatic quote_t toggle_quote(input quote_t q, input quote_t qc);
		if (q == Q_NONE) return qc;
		if (q == qc) return Q_NONE;
		return q;
	endfunction

endpackage

>>> hdl/sprs_stream_if.sv
// Valid/ready channel interfaces for character input and status output.
// Depends on nothing.

interface sprs_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_line;

	modport source (output valid, output ch, output end_of_line, input ready);
	modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface sprs_status_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       ok;

	modport source (output valid, output status, output ok, input ready);
	modport sink   (input valid, input status, input ok, output ready);
endinterface

>>> hdl/sprs_core.sv
// Per-character state of the redirection and pipe checks, plus the end of
// line status decision. Depends on sprs_pkg.

module sprs_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           ch,
	input  logic                 end_of_line,
	output sprs_pkg::status_t    status
);
	import sprs_pkg::*;

	chk_state_t st_q;
	chk_state_t st_char;
	chk_state_t st_nxt;

	quote_t qc;
	logic   blank;
	logic   redir;
	logic   pipe;
	logic   redir_err_end;
	perr_t  perr_end;

	assign qc    = quote_code(ch);
	assign blank = is_blank(ch);
	assign redir = is_redir(ch);
	assign pipe  = (ch == CH_PIPE);

	// Character update
	always_comb begin
		st_char = st_q;

		if (!st_q.redir_error_flag) begin
			unique case (st_q.redir_phase)
				PH_OP_LT, PH_OP_GT: begin
					// second char of << or >> just moves on; otherwise treat as after-op
					st_char.redir_phase = PH_AFTER_OP;
					if (!(ch == ((st_q.redir_phase == PH_OP_LT) ? CH_LT : CH_GT))) begin
						if (pipe || redir) begin
							st_char.redir_error_flag = 1'b1;
						end else if (!blank) begin
							if (qc != Q_NONE) begin
								st_char.file_word_quote = qc;
								st_char.redir_phase     = PH_WORD_QUOTE;
							end else begin
								st_char.redir_phase = PH_WORD;
							end
						end
					end
				end
				PH_AFTER_OP: begin
					if (pipe || redir) begin
						st_char.redir_error_flag = 1'b1;
					end else if (!blank) begin
						if (qc != Q_NONE) begin
							st_char.file_word_quote = qc;
							st_char.redir_phase     = PH_WORD_QUOTE;
						end else begin
							st_char.redir_phase = PH_WORD;
						end
					end
				end
				PH_WORD: begin
					if (blank || pipe || redir) begin
						st_char.redir_phase = PH_IDLE;
						if (redir && st_q.redir_outer_quote == Q_NONE)
							st_char.redir_phase = (ch == CH_LT) ? PH_OP_LT : PH_OP_GT;
					end else if (qc != Q_NONE) begin
						st_char.file_word_quote = qc;
						st_char.redir_phase     = PH_WORD_QUOTE;
					end
				end
				PH_WORD_QUOTE: begin
					if (qc == st_q.file_word_quote) st_char.redir_phase = PH_WORD;
				end
				default: begin
					st_char.redir_phase = PH_IDLE;
					if (qc != Q_NONE) begin
						st_char.redir_outer_quote = toggle_quote(st_q.redir_outer_quote, qc);
					end else if (st_q.redir_outer_quote == Q_NONE && redir) begin
						st_char.redir_phase = (ch == CH_LT) ? PH_OP_LT : PH_OP_GT;
					end
				end
			endcase
		end

		// pipe check
		if (!blank) begin
			if (!st_q.seen_nonblank) begin
				st_char.seen_nonblank = 1'b1;
				if (pipe) st_char.leading_pipe_flag = 1'b1;
			end
			if (st_q.pipe_lookahead_pending) begin
				st_char.pipe_lookahead_pending = 1'b0;
				if (pipe && st_q.pipe_error_code == PE_NONE)
					st_char.pipe_error_code = PE_END_OR_PIPE;
			end
		end
		if (qc != Q_NONE) begin
			st_char.pipe_pass_quote = toggle_quote(st_q.pipe_pass_quote, qc);
		end else if (pipe && st_q.pipe_pass_quote == Q_NONE) begin
			if (st_q.previous_was_pipe && st_char.pipe_error_code == PE_NONE)
				st_char.pipe_error_code = PE_REPEATED;
			st_char.previous_was_pipe      = 1'b1;
			st_char.pipe_lookahead_pending = 1'b1;
		end else if (!blank) begin
			st_char.previous_was_pipe = 1'b0;
		end
	end

	// End of line decision
	always_comb begin
		redir_err_end = st_q.redir_error_flag || (st_q.redir_phase == PH_OP_LT) ||
			(st_q.redir_phase == PH_OP_GT) || (st_q.redir_phase == PH_AFTER_OP);
		perr_end = st_q.pipe_error_code;
		if (perr_end == PE_NONE && (st_q.pipe_lookahead_pending || st_q.previous_was_pipe))
			perr_end = PE_END_OR_PIPE;

		if (st_q.leading_pipe_flag)      status = ST_LEADING_PIPE;
		else if (redir_err_end)          status = ST_REDIR_NOFILE;
		else if (perr_end == PE_REPEATED) status = ST_REPEAT_PIPE;
		else if (perr_end == PE_END_OR_PIPE) status = ST_PIPE_AT_END;
		else                             status = ST_OK;
	end

	assign st_nxt = end_of_line ? CHK_RESET : st_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CHK_RESET;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

endmodule

>>> hdl/shell_pipe_redirect_syntax_check.sv
// Shell pipe and redirection syntax checker, top level.
// Output path: after its end-of-line transaction is accepted, a status is held in the input stage
// register and then registered in the output register, from which it is presented on result.
// Throughput: one character per cycle while no end-of-line transaction waits for the output register.
// The output register lets ordinary characters in while a status waits to be taken; only a
// further end-of-line transaction waits for it.
// Reset clears all check state and the stage and output valid flags at once.
// Depends on sprs_pkg, sprs_stream_if and sprs_core.

module shell_pipe_redirect_syntax_check (
	input  logic  clk,
	input  logic  arst_n,
	sprs_char_if.sink     chars,
	sprs_status_if.source result
);
	import sprs_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eol_s1;
	logic       advance;
	logic       step;
	logic       out_valid_q;
	logic [2:0] status_q;
	status_t    status;

	// only an end-of-line transaction needs room in the output register
	assign advance     = !valid_s1 || !eol_s1 || !out_valid_q || result.ready;
	assign step        = valid_s1 && advance;
	assign chars.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && chars.valid) begin
			ch_s1  <= chars.ch;
			eol_s1 <= chars.end_of_line;
		end
	end

	sprs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.ch          (ch_s1),
		.end_of_line (eol_s1),
		.status      (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && eol_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && eol_s1) status_q <= status;
	end

	assign result.valid  = out_valid_q;
	assign result.status = status_q;
	assign result.ok     = (status_q == ST_OK);

endmodule
